/* hdl/hyperelliptic_pointless_test_mod_p_top_assert.svh */
// Assertion macros for the pointless-curve counter.
`ifndef HYPERELLIPTIC_POINTLESS_TEST_MOD_P_TOP_ASSERT_SVH
`define HYPERELLIPTIC_POINTLESS_TEST_MOD_P_TOP_ASSERT_SVH

// Same-cycle implication.
`define HPTM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HPTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/hptm_pkg.sv */
package hptm_pkg;

   localparam int unsigned MAX_PRIME_DEF = 128;
   localparam int unsigned ResW  = 7;    // residue / coefficient width
   localparam int unsigned CntW  = 8;    // point counts
   localparam int unsigned TotW  = 64;   // running totals
   localparam int unsigned HalfW = 13;   // p(p-1)/2
   localparam int unsigned NCoef = 12;   // f0..f11 on the input
   localparam int unsigned NTerm = 14;   // f0..f13
   localparam int unsigned NDer  = 13;   // f'0..f'12
   localparam logic [ResW-1:0] RESET_PRIME = 7'd3;

   // quadratic character codes held in the residue table
   localparam logic [1:0] RES_NONSQ  = 2'd0;
   localparam logic [1:0] RES_ZERO   = 2'd1;
   localparam logic [1:0] RES_SQUARE = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_FILL,
      ST_IDLE,
      ST_PREP_C,
      ST_PREP_D,
      ST_HORNER,
      ST_LOOKUP,
      ST_TALLY,
      ST_FINISH
   } state_type;

   typedef logic [ResW-1:0] residue_type;

   // odd primes below 128 other than 13
   function automatic logic prime_ok(input logic [ResW-1:0] v);
      logic ok;
      case (v) inside
         7'd3, 7'd5, 7'd7, 7'd11, 7'd17, 7'd19, 7'd23, 7'd29, 7'd31, 7'd37,
         7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73,
         7'd79, 7'd83, 7'd89, 7'd97, 7'd101, 7'd103, 7'd107, 7'd109,
         7'd113, 7'd127: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

/* hdl/hptm_if.sv */
interface hptm_req_if;
   logic valid;
   logic ready;
   logic [hptm_pkg::ResW-1:0] coef_0, coef_1, coef_2, coef_3, coef_4, coef_5;
   logic [hptm_pkg::ResW-1:0] coef_6, coef_7, coef_8, coef_9, coef_10, coef_11;
   modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                   coef_6, coef_7, coef_8, coef_9, coef_10, coef_11, input ready);
   modport sink (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                 coef_6, coef_7, coef_8, coef_9, coef_10, coef_11, output ready);
endinterface

interface hptm_rsp_if;
   logic valid;
   logic ready;
   logic [hptm_pkg::CntW-1:0] point_count;
   logic plain_pointless;
   logic twist_pointless;
   logic [hptm_pkg::TotW-1:0] plain_orbit_total;
   logic [hptm_pkg::TotW-1:0] plain_curve_total;
   logic [hptm_pkg::TotW-1:0] twist_orbit_total;
   logic [hptm_pkg::TotW-1:0] twist_curve_total;
   logic [hptm_pkg::CntW-1:0] least_count;
   modport source (output valid, point_count, plain_pointless, twist_pointless,
                   plain_orbit_total, plain_curve_total, twist_orbit_total,
                   twist_curve_total, least_count, input ready);
   modport sink (input valid, point_count, plain_pointless, twist_pointless,
                 plain_orbit_total, plain_curve_total, twist_orbit_total,
                 twist_curve_total, least_count, output ready);
endinterface

interface hptm_csr_if;
   logic valid;
   logic ready;
   logic [hptm_pkg::ResW-1:0] prime_modulus;
   modport source (output valid, prime_modulus, input ready);
   modport sink (input valid, prime_modulus, output ready);
endinterface

/* hdl/hyperelliptic_pointless_test_mod_p_top.sv */
// Channel   Role     Payload
// req_chan  sink     coef_0 .. coef_11
// rsp_chan  source   point_count, pointless flags, four totals, least_count
// csr_chan  sink     prime_modulus
//
// One item scans up to p points. Every modular multiply-add runs
// bit-serially; 25 of them reduce the coefficients and form f', and
// each point needs 14 of them plus a residue table read. After reset
// and each accepted modulus write the table is rebuilt; req_chan is not
// ready then. A pending response stalls only the finish of the next item.
module hyperelliptic_pointless_test_mod_p_top #(
   parameter int unsigned MAX_PRIME = hptm_pkg::MAX_PRIME_DEF
) (
   input  logic          clock,
   input  logic          reset,
   hptm_req_if.sink      req_chan,
   hptm_rsp_if.source    rsp_chan,
   hptm_csr_if.sink      csr_chan
);
   import hptm_pkg::*;

   localparam int unsigned AW = $clog2(MAX_PRIME);

   state_type state_ff, state_in;

   // configuration
   residue_type            prime_ff;
   logic [HalfW-1:0]       half_ff;
   logic [HalfW-1:0]       quarter;
   residue_type            load_p;
   logic [2*ResW-1:0]      load_prod;
   logic                   csr_load, load_now;

   // residue table
   logic [1:0]             rtab_mem [MAX_PRIME];
   logic [1:0]             rtab_rd_ff;
   logic [AW-1:0]          rd_addr, wr_addr, clr_ff;
   logic [1:0]             wr_data;
   logic                   wr_en;
   residue_type            fill_i_ff, sq_ff, odd_ff;
   logic [ResW:0]          sq_sum, odd_sum;

   // coefficients
   residue_type            coef_raw_ff [NCoef];
   residue_type            cr_ff [NTerm];
   residue_type            dr_ff [NDer];
   logic [3:0]             j_ff, s_ff, d_idx;
   logic [2:0]             cyc_ff;
   logic                   op_last;

   // two serial multiply-add lanes: f and f'
   residue_type            acc_ff [2];
   residue_type            r_ff [2];
   residue_type            a_sel [2];
   residue_type            e_sel [2];
   residue_type            r_next [2];
   residue_type            b_sel;
   logic [ResW:0]          b_ext;
   logic [ResW+1:0]        t_raw [2];
   logic [ResW+1:0]        t_red [2];
   logic                   b_bit;

   // scan
   residue_type            x_ff;
   logic [CntW-1:0]        cnt_ff, ucnt_ff, cnt_in, ucnt_in;
   logic                   counted, stop;

   // totals
   logic [TotW-1:0]        po_ff, pc_ff, to_ff, tc_ff;
   logic [CntW-1:0]        least_ff;
   logic                   pz, tz, f11z, other_side;
   logic [HalfW-1:0]       weight;
   logic [1:0]             po_add, to_add;
   logic [HalfW:0]         pc_add, tc_add;

   logic                   req_fire, rsp_free, rsp_valid_ff;
   logic [CntW-1:0]        out_cnt_ff;
   logic                   out_pz_ff, out_tz_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign csr_load = csr_chan.valid && prime_ok(csr_chan.prime_modulus)
                     && (32'(csr_chan.prime_modulus) <= MAX_PRIME);
   assign load_now = reset || csr_load;
   assign load_p   = reset ? RESET_PRIME : csr_chan.prime_modulus;
   assign load_prod = (2*ResW)'(load_p) * (2*ResW)'(load_p - 7'd1);
   assign quarter  = half_ff >> 1;
   assign op_last  = (cyc_ff == 3'd7);

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == AW'(MAX_PRIME - 1)) state_in = ST_FILL;
         ST_FILL:   if (fill_i_ff == prime_ff - 7'd1) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_PREP_C;
         ST_PREP_C: if (op_last && j_ff == 4'(NCoef - 1)) state_in = ST_PREP_D;
         ST_PREP_D: if (op_last && j_ff == 4'(NDer - 1)) state_in = ST_HORNER;
         ST_HORNER: if (op_last && s_ff == 4'(NTerm - 1)) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_TALLY;
         ST_TALLY:  state_in = stop ? ST_FINISH : ST_HORNER;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
      if (csr_load) state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // table write port: clear sweep, then squares i*i mod p
   assign odd_sum = {1'b0, odd_ff} + 8'd2;
   assign sq_sum  = {1'b0, sq_ff} + {1'b0, odd_ff};
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = (clr_ff == '0) ? RES_ZERO : RES_NONSQ;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_FILL) begin
         wr_en   = 1'b1;
         wr_addr = AW'(sq_ff);
         wr_data = RES_SQUARE;
      end
   end
   assign rd_addr = AW'(acc_ff[0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rtab_mem[wr_addr] <= wr_data;
      end
      rtab_rd_ff <= rtab_mem[rd_addr];
   end

   // operand selection for the lanes
   assign d_idx = (s_ff == 4'd0) ? 4'd0 : 4'(NTerm - 1) - s_ff;
   always_comb begin
      b_sel    = x_ff;
      a_sel[0] = acc_ff[0];
      a_sel[1] = acc_ff[1];
      e_sel[0] = cr_ff[4'(NTerm - 1) - s_ff];
      e_sel[1] = (s_ff == 4'd0) ? '0 : dr_ff[d_idx];
      if (state_ff == ST_PREP_C) begin
         b_sel    = coef_raw_ff[j_ff];
         a_sel[0] = 7'd1;
         a_sel[1] = 7'd1;
         e_sel[0] = '0;
         e_sel[1] = '0;
      end else if (state_ff == ST_PREP_D) begin
         b_sel    = 7'(j_ff + 4'd1);
         a_sel[0] = cr_ff[j_ff + 4'd1];
         a_sel[1] = '0;
         e_sel[0] = '0;
         e_sel[1] = '0;
      end
   end

   // one bit of a*b (MSB first) per cycle, then + e on the last cycle
   assign b_ext = {1'b0, b_sel};
   assign b_bit = b_ext[3'd6 - cyc_ff];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (op_last) begin
            t_raw[l] = {2'b00, r_ff[l]} + {2'b00, e_sel[l]};
         end else begin
            t_raw[l] = {1'b0, r_ff[l], 1'b0} + (b_bit ? {2'b00, a_sel[l]} : '0);
         end
         if (t_raw[l] >= {1'b0, prime_ff, 1'b0}) begin
            t_red[l] = t_raw[l] - {1'b0, prime_ff, 1'b0};
         end else if (t_raw[l] >= {2'b00, prime_ff}) begin
            t_red[l] = t_raw[l] - {2'b00, prime_ff};
         end else begin
            t_red[l] = t_raw[l];
         end
         r_next[l] = ResW'(t_red[l]);
      end
   end

   // point tally
   always_comb begin
      counted = (rtab_rd_ff != RES_ZERO) || (acc_ff[1] != '0);
      cnt_in  = cnt_ff + (counted ? CntW'(rtab_rd_ff) : '0);
      ucnt_in = ucnt_ff + (counted ? CntW'(2'd2 - rtab_rd_ff) : '0);
      stop    = (cnt_in != '0 && ucnt_in != '0) || (x_ff == prime_ff - 7'd1);
   end

   // orbit weights
   always_comb begin
      pz         = (cnt_ff == '0);
      tz         = (ucnt_ff == '0);
      f11z       = (cr_ff[NCoef - 1] == '0);
      other_side = !f11z && (prime_ff[1:0] != 2'b11);
      if (f11z) begin
         weight = HalfW'(prime_ff);
      end else if (prime_ff[1:0] == 2'b11) begin
         weight = half_ff;
      end else begin
         weight = quarter;
      end
      po_add = 2'(pz) + 2'(tz && other_side);
      to_add = 2'(tz) + 2'(pz && other_side);
      pc_add = (pz ? {1'b0, weight} : '0) + ((tz && other_side) ? {1'b0, quarter} : '0);
      tc_add = (tz ? {1'b0, weight} : '0) + ((pz && other_side) ? {1'b0, quarter} : '0);
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (load_now) begin
         prime_ff  <= load_p;
         half_ff   <= HalfW'(load_prod >> 1);
         po_ff     <= '0;
         pc_ff     <= '0;
         to_ff     <= '0;
         tc_ff     <= '0;
         least_ff  <= {load_p, 1'b1};
         clr_ff    <= '0;
         fill_i_ff <= 7'd1;
         sq_ff     <= 7'd1;
         odd_ff    <= (load_p == 7'd3) ? 7'd0 : 7'd3;
         cyc_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
            end
            ST_FILL: begin
               fill_i_ff <= fill_i_ff + 7'd1;
               odd_ff    <= (odd_sum >= {1'b0, prime_ff}) ?
                            ResW'(odd_sum - {1'b0, prime_ff}) : ResW'(odd_sum);
               sq_ff     <= (sq_sum >= {1'b0, prime_ff}) ?
                            ResW'(sq_sum - {1'b0, prime_ff}) : ResW'(sq_sum);
            end
            ST_IDLE: begin
               coef_raw_ff[0]  <= req_chan.coef_0;
               coef_raw_ff[1]  <= req_chan.coef_1;
               coef_raw_ff[2]  <= req_chan.coef_2;
               coef_raw_ff[3]  <= req_chan.coef_3;
               coef_raw_ff[4]  <= req_chan.coef_4;
               coef_raw_ff[5]  <= req_chan.coef_5;
               coef_raw_ff[6]  <= req_chan.coef_6;
               coef_raw_ff[7]  <= req_chan.coef_7;
               coef_raw_ff[8]  <= req_chan.coef_8;
               coef_raw_ff[9]  <= req_chan.coef_9;
               coef_raw_ff[10] <= req_chan.coef_10;
               coef_raw_ff[11] <= req_chan.coef_11;
               cr_ff[NTerm - 2] <= '0;
               cr_ff[NTerm - 1] <= 7'd1;
               j_ff    <= '0;
               s_ff    <= '0;
               cyc_ff  <= '0;
               x_ff    <= '0;
               cnt_ff  <= '0;
               ucnt_ff <= '0;
               r_ff[0] <= '0;
               r_ff[1] <= '0;
               acc_ff[0] <= '0;
               acc_ff[1] <= '0;
            end
            ST_PREP_C, ST_PREP_D, ST_HORNER: begin
               cyc_ff <= cyc_ff + 3'd1;
               for (int l = 0; l < 2; l++) begin
                  r_ff[l] <= op_last ? '0 : r_next[l];
               end
               if (op_last) begin
                  if (state_ff == ST_PREP_C) begin
                     cr_ff[j_ff] <= r_next[0];
                     j_ff <= (j_ff == 4'(NCoef - 1)) ? '0 : j_ff + 4'd1;
                  end else if (state_ff == ST_PREP_D) begin
                     dr_ff[j_ff] <= r_next[0];
                     j_ff <= j_ff + 4'd1;
                  end else begin
                     acc_ff[0] <= r_next[0];
                     acc_ff[1] <= r_next[1];
                     s_ff <= s_ff + 4'd1;
                  end
               end
            end
            ST_LOOKUP: begin
               s_ff <= '0;
            end
            ST_TALLY: begin
               cnt_ff    <= cnt_in;
               ucnt_ff   <= ucnt_in;
               x_ff      <= x_ff + 7'd1;
               acc_ff[0] <= '0;
               acc_ff[1] <= '0;
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  po_ff    <= po_ff + TotW'(po_add);
                  to_ff    <= to_ff + TotW'(to_add);
                  pc_ff    <= pc_ff + TotW'(pc_add);
                  tc_ff    <= tc_ff + TotW'(tc_add);
                  least_ff <= (cnt_ff < least_ff) ? cnt_ff : least_ff;
               end
            end
            default: begin
               cyc_ff <= '0;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         out_cnt_ff <= cnt_ff;
         out_pz_ff  <= pz;
         out_tz_ff  <= tz;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.point_count       = out_cnt_ff;
   assign rsp_chan.plain_pointless   = out_pz_ff;
   assign rsp_chan.twist_pointless   = out_tz_ff;
   assign rsp_chan.plain_orbit_total = po_ff;
   assign rsp_chan.plain_curve_total = pc_ff;
   assign rsp_chan.twist_orbit_total = to_ff;
   assign rsp_chan.twist_curve_total = tc_ff;
   assign rsp_chan.least_count       = least_ff;

   // checks
`include "hyperelliptic_pointless_test_mod_p_top_assert.svh"

   `HPTM_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == ST_PREP_C || state_ff == ST_CLEAR, "accepted transaction did not start coefficient reduction")
   `HPTM_ASSERT_NOW(a_lookup_reduced, clock, reset, state_ff == ST_LOOKUP, acc_ff[0] < prime_ff, "f(x) not reduced below the modulus")
   `HPTM_ASSERT_NOW(a_square_nonzero, clock, reset, state_ff == ST_FILL, sq_ff != '0 && sq_ff < prime_ff, "square residue out of range")

endmodule

/* tb/sv/tb_hyperelliptic_pointless_test_mod_p_top.sv */
module tb_hyperelliptic_pointless_test_mod_p_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hptm_pkg::*;

   // generous bound on the length of the whole run
   localparam int unsigned CYCLE_LIMIT = 40_000_000;
   localparam int unsigned LONG_HOLD   = 4000;

   typedef struct packed {
      logic [CntW-1:0] point_count;
      logic            plain_pointless;
      logic            twist_pointless;
      logic [TotW-1:0] plain_orbit_total;
      logic [TotW-1:0] plain_curve_total;
      logic [TotW-1:0] twist_orbit_total;
      logic [TotW-1:0] twist_curve_total;
      logic [CntW-1:0] least_count;
   } tally_type;

   typedef residue_type coef_vec_type [NCoef];

   // Point-count predictor and store of expected tallies
   class pointless_scoreboard;
      int unsigned     prime;
      logic [1:0]      chi [MAX_PRIME_DEF];
      longint unsigned plain_orbits, plain_curves, twist_orbits, twist_curves;
      int unsigned     lowest;
      tally_type       tally_q [$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         set_modulus(RESET_PRIME);
      endfunction

      // Ignored unless v is an odd prime in range other than 13
      function void set_modulus(int unsigned v);
         int unsigned d;
         if (v < 3 || v > 127 || v == 13) return;
         for (d = 2; d * d <= v; d++)
            if (v % d == 0) return;
         prime = v;
         foreach (chi[i]) chi[i] = RES_NONSQ;
         chi[0] = RES_ZERO;
         for (d = 1; d < v; d++) chi[(d * d) % v] = RES_SQUARE;
         plain_orbits = 0;
         plain_curves = 0;
         twist_orbits = 0;
         twist_curves = 0;
         lowest = 2 * v + 1;
      endfunction

      function void note_request(coef_vec_type coefs);
         int unsigned c [NTerm];
         int unsigned d [NDer];
         int unsigned cnt, ucnt, fv, dv, ny, half, quarter, x;
         bit          f11_zero;
         tally_type   t;
         cnt = 0;
         ucnt = 0;
         half = prime * (prime - 1) / 2;
         quarter = half / 2;
         for (int k = 0; k < NCoef; k++) c[k] = coefs[k] % prime;
         c[12] = 0;
         c[13] = 1;
         for (int k = 0; k < NDer; k++) d[k] = ((k + 1) * c[k + 1]) % prime;
         f11_zero = (c[11] == 0);
         for (x = 0; x < prime && (cnt == 0 || ucnt == 0); x++) begin
            fv = c[13];
            dv = d[12];
            for (int k = 12; k >= 0; k--) fv = (fv * x + c[k]) % prime;
            for (int k = 11; k >= 0; k--) dv = (dv * x + d[k]) % prime;
            ny = chi[fv];
            // a zero of f counts only where f' is nonzero
            if (ny != RES_ZERO || dv != 0) begin
               cnt += ny;
               ucnt += 2 - ny;
            end
         end
         if (cnt == 0) begin
            plain_orbits++;
            if (f11_zero) plain_curves += prime;
            else if ((prime & 3) == 3) plain_curves += half;
            else begin
               twist_orbits++;
               plain_curves += quarter;
               twist_curves += quarter;
            end
         end
         if (ucnt == 0) begin
            twist_orbits++;
            if (f11_zero) twist_curves += prime;
            else if ((prime & 3) == 3) twist_curves += half;
            else begin
               plain_orbits++;
               plain_curves += quarter;
               twist_curves += quarter;
            end
         end
         if (cnt < lowest) lowest = cnt;
         t.point_count       = cnt[CntW-1:0];
         t.plain_pointless   = (cnt == 0);
         t.twist_pointless   = (ucnt == 0);
         t.plain_orbit_total = plain_orbits;
         t.plain_curve_total = plain_curves;
         t.twist_orbit_total = twist_orbits;
         t.twist_curve_total = twist_curves;
         t.least_count       = lowest[CntW-1:0];
         tally_q.push_back(t);
      endfunction

      function void check_response(tally_type got);
         tally_type want;
         if (tally_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: response with nothing expected, count=%0d", got.point_count);
            return;
         end
         want = tally_q.pop_front();
         if (got.point_count !== want.point_count ||
             got.plain_pointless !== want.plain_pointless ||
             got.twist_pointless !== want.twist_pointless ||
             got.plain_orbit_total !== want.plain_orbit_total ||
             got.plain_curve_total !== want.plain_curve_total ||
             got.twist_orbit_total !== want.twist_orbit_total ||
             got.twist_curve_total !== want.twist_curve_total ||
             got.least_count !== want.least_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("tb: mismatch p=%0d", prime);
               $display("tb: exp cnt=%0d pp=%0b tp=%0b po=%0d pc=%0d to=%0d tc=%0d min=%0d",
                        want.point_count, want.plain_pointless, want.twist_pointless,
                        want.plain_orbit_total, want.plain_curve_total,
                        want.twist_orbit_total, want.twist_curve_total, want.least_count);
               $display("tb: act cnt=%0d pp=%0b tp=%0b po=%0d pc=%0d to=%0d tc=%0d min=%0d",
                        got.point_count, got.plain_pointless, got.twist_pointless,
                        got.plain_orbit_total, got.plain_curve_total,
                        got.twist_orbit_total, got.twist_curve_total, got.least_count);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   hptm_req_if req_chan ();
   hptm_rsp_if rsp_chan ();
   hptm_csr_if csr_chan ();

   hyperelliptic_pointless_test_mod_p_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pointless_scoreboard sb = new();
   int unsigned idle_pct;      // chance of an idle burst, both sides
   bit          hold_request;  // asks the receiver for one long stall
   int unsigned cycle_count;
   int unsigned cur_prime;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response receiver with random stalls and one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response('{rsp_chan.point_count, rsp_chan.plain_pointless,
                             rsp_chan.twist_pointless, rsp_chan.plain_orbit_total,
                             rsp_chan.plain_curve_total, rsp_chan.twist_orbit_total,
                             rsp_chan.twist_curve_total, rsp_chan.least_count});
   end

   // one request transaction; valid stays high afterwards
   task automatic send_poly(coef_vec_type c);
      req_chan.valid   <= 1'b1;
      req_chan.coef_0  <= c[0];
      req_chan.coef_1  <= c[1];
      req_chan.coef_2  <= c[2];
      req_chan.coef_3  <= c[3];
      req_chan.coef_4  <= c[4];
      req_chan.coef_5  <= c[5];
      req_chan.coef_6  <= c[6];
      req_chan.coef_7  <= c[7];
      req_chan.coef_8  <= c[8];
      req_chan.coef_9  <= c[9];
      req_chan.coef_10 <= c[10];
      req_chan.coef_11 <= c[11];
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(c);
   endtask

   task automatic sender_gap();
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // modulus write only once all tallies are back
   task automatic write_modulus(int unsigned v);
      req_chan.valid <= 1'b0;
      while (sb.tally_q.size() != 0) @(posedge clock);
      csr_chan.valid         <= 1'b1;
      csr_chan.prime_modulus <= v[ResW-1:0];
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      sb.set_modulus(v);
      cur_prime = sb.prime;
   endtask

   function automatic coef_vec_type uniform_poly(int unsigned hi, int unsigned f11_zero_pct);
      coef_vec_type c;
      foreach (c[k]) c[k] = $urandom_range(0, hi);
      if ($urandom_range(0, 99) < f11_zero_pct) c[11] = '0;
      return c;
   endfunction

   function automatic coef_vec_type sparse_poly(int unsigned hi);
      coef_vec_type c;
      foreach (c[k]) c[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hi) : 0;
      return c;
   endfunction

   task automatic random_phase(int unsigned p, int unsigned n, int unsigned idl, bit hold);
      int unsigned pick;
      write_modulus(p);
      idle_pct = idl;
      // long receiver hold-off while requests keep coming
      if (hold) hold_request = 1'b1;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         // mostly reduced coefficients, some sparse, some raw 7-bit noise
         if (pick < 6) send_poly(uniform_poly(p - 1, 25));
         else if (pick < 8) send_poly(sparse_poly(p - 1));
         else send_poly(uniform_poly(127, 10));
         sender_gap();
      end
   endtask

   initial begin
      coef_vec_type c;
      int unsigned phase_prime [12] = '{3, 5, 7, 11, 17, 3, 61, 5, 7, 127, 19, 3};
      int unsigned phase_items [12] = '{170, 170, 170, 170, 170, 170, 30, 170, 170, 15,
                                        170, 170};

      reset    = 1'b1;
      idle_pct = 0;
      hold_request = 1'b0;
      cur_prime = RESET_PRIME;
      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.prime_modulus <= '0;
      foreach (c[k]) c[k] = '0;
      req_chan.coef_0 <= '0; req_chan.coef_1 <= '0; req_chan.coef_2 <= '0;
      req_chan.coef_3 <= '0; req_chan.coef_4 <= '0; req_chan.coef_5 <= '0;
      req_chan.coef_6 <= '0; req_chan.coef_7 <= '0; req_chan.coef_8 <= '0;
      req_chan.coef_9 <= '0; req_chan.coef_10 <= '0; req_chan.coef_11 <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset modulus, zero and all-ones coefficients (reduced mod p)
      send_poly(c);
      foreach (c[k]) c[k] = 7'h7f;
      send_poly(c);
      c[11] = '0;
      send_poly(c);
      foreach (c[k]) c[k] = '0;
      c[0] = 7'd1;
      send_poly(c);
      c[0] = 7'd2;
      send_poly(c);
      // rejected writes keep p and totals
      write_modulus(13);
      send_poly(c);
      write_modulus(0);
      write_modulus(9);
      write_modulus(126);
      write_modulus(2);
      send_poly(c);
      // p = 1 mod 4 weighting
      write_modulus(5);
      foreach (c[k]) c[k] = '0;
      send_poly(c);
      c[0] = 7'd2; c[11] = 7'd1;
      send_poly(c);
      c[11] = '0;
      send_poly(c);
      c[0] = 7'd3; c[1] = 7'd5; c[11] = 7'd4;
      send_poly(c);
      // same value rewritten clears the totals
      write_modulus(5);
      send_poly(c);
      // largest modulus
      write_modulus(127);
      foreach (c[k]) c[k] = '0;
      send_poly(c);
      foreach (c[k]) c[k] = 7'd126;
      send_poly(c);
      foreach (c[k]) c[k] = 7'h7f;
      send_poly(c);
      c[11] = '0;
      send_poly(c);

      // random phases; second one starts with a long receiver hold-off
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) write_modulus(13);
         random_phase(phase_prime[ph], phase_items[ph],
                      (ph == 11) ? 0 : ((ph % 4 == 2) ? 0 : 30), ph == 1);
      end

      req_chan.valid <= 1'b0;
      while (sb.tally_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0 && sb.tally_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/hptm_pkg.sv
hdl/hptm_if.sv
hdl/hyperelliptic_pointless_test_mod_p_top.sv
tb/sv/tb_hyperelliptic_pointless_test_mod_p_top.sv
